### rtl/core/vector_tilt_angle_detector_top_macros.svh
// Assertion macros shared by the tilt detector checker.
`ifndef VECTOR_TILT_ANGLE_DETECTOR_TOP_MACROS_SVH
`define VECTOR_TILT_ANGLE_DETECTOR_TOP_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define VTAD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define VTAD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/vtad_pkg.sv
// Shared constants, codes and types of the tilt angle detector.
package vtad_pkg;

    localparam int SAMPLE_WIDTH_DEF  = 16;
    localparam int COS_FRAC_BITS_DEF = 14;
    localparam int COS_W             = 16;
    localparam int CM2_W             = 2 * COS_W - 1;
    localparam int CFG_IDX_W         = 3;

    localparam logic [CFG_IDX_W-1:0] REG_REF_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REF_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REF_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COS   = 3'd3;

    localparam logic signed [COS_W-1:0] COS_RESET = 16'sd14189;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_A_ZERO = 2'd1;
    localparam logic [1:0] ST_B_ZERO = 2'd2;

    typedef struct packed {
        logic [1:0] status;
        logic       decided;
        logic       tilt;
        logic       dneg;
    } t_cls;

endpackage

### rtl/core/vtad_cfg.sv
// Configuration registers: reference vector and cosine threshold.
module vtad_cfg #(
    parameter int SAMPLE_WIDTH = vtad_pkg::SAMPLE_WIDTH_DEF,
    parameter int CFG_DATA_W   = (SAMPLE_WIDTH > vtad_pkg::COS_W) ? SAMPLE_WIDTH
                                                                 : vtad_pkg::COS_W
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [vtad_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]                i_cfg_data,
    output logic signed [SAMPLE_WIDTH-1:0]       o_ref_x,
    output logic signed [SAMPLE_WIDTH-1:0]       o_ref_y,
    output logic signed [SAMPLE_WIDTH-1:0]       o_ref_z,
    output logic signed [vtad_pkg::COS_W-1:0]    o_cos
);
    import vtad_pkg::*;

    logic signed [SAMPLE_WIDTH-1:0] r_ref_x, r_ref_y, r_ref_z;
    logic signed [COS_W-1:0]        r_cos;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_x <= '0;
            r_ref_y <= '0;
            r_ref_z <= '0;
            r_cos   <= COS_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_REF_X: r_ref_x <= i_cfg_data[SAMPLE_WIDTH-1:0];
                REG_REF_Y: r_ref_y <= i_cfg_data[SAMPLE_WIDTH-1:0];
                REG_REF_Z: r_ref_z <= i_cfg_data[SAMPLE_WIDTH-1:0];
                REG_COS:   r_cos   <= i_cfg_data[COS_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_ref_x = r_ref_x;
    assign o_ref_y = r_ref_y;
    assign o_ref_z = r_ref_z;
    assign o_cos   = r_cos;

endmodule

### rtl/core/vtad_dot.sv
// Front pipeline: per-axis products, dot and length sums, sign classification.
module vtad_dot #(
    parameter int SAMPLE_WIDTH = vtad_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_hold,
    input  logic signed [SAMPLE_WIDTH-1:0]     i_sample_x,
    input  logic signed [SAMPLE_WIDTH-1:0]     i_sample_y,
    input  logic signed [SAMPLE_WIDTH-1:0]     i_sample_z,
    input  logic signed [SAMPLE_WIDTH-1:0]     i_ref_x,
    input  logic signed [SAMPLE_WIDTH-1:0]     i_ref_y,
    input  logic signed [SAMPLE_WIDTH-1:0]     i_ref_z,
    input  logic signed [vtad_pkg::COS_W-1:0]  i_cos,
    output logic                               o_valid,
    input  logic                               i_hold,
    output logic [2*SAMPLE_WIDTH-1:0]          o_dmag,
    output logic [2*SAMPLE_WIDTH-1:0]          o_len_a,
    output logic [2*SAMPLE_WIDTH-1:0]          o_len_b,
    output logic [vtad_pkg::COS_W-1:0]         o_cmag,
    output vtad_pkg::t_cls                     o_cls
);
    import vtad_pkg::*;

    localparam int W  = SAMPLE_WIDTH;
    localparam int HW = 2 * SAMPLE_WIDTH;

    logic en1, en2, en3;

    logic signed [W-1:0] s_a [3];
    logic signed [W-1:0] s_b [3];
    logic [W-1:0]        s_ma [3];
    logic [W-1:0]        s_mb [3];

    logic [HW-1:0] n_s1_pab [3];
    logic [HW-1:0] n_s1_paa [3];
    logic [HW-1:0] n_s1_pbb [3];
    logic [2:0]    n_s1_neg;
    logic          r_s1_v;
    logic [HW-1:0] r_s1_pab [3];
    logic [HW-1:0] r_s1_paa [3];
    logic [HW-1:0] r_s1_pbb [3];
    logic [2:0]    r_s1_neg;

    logic [HW-1:0] n_s2_pos, n_s2_neg, n_s2_la, n_s2_lb;
    logic          r_s2_v;
    logic [HW-1:0] r_s2_pos, r_s2_neg, r_s2_la, r_s2_lb;

    logic          s_dneg;
    logic [HW-1:0] n_s3_dmag;
    logic [COS_W-1:0] n_s3_cmag;
    t_cls          n_s3_cls;
    logic          r_s3_v;
    logic [HW-1:0] r_s3_dmag, r_s3_la, r_s3_lb;
    logic [COS_W-1:0] r_s3_cmag;
    t_cls          r_s3_cls;

    assign en3    = !r_s3_v || !i_hold;
    assign en2    = !r_s2_v || en3;
    assign en1    = !r_s1_v || en2;
    assign o_hold = !en1;

    // stage 1: magnitudes and products per axis
    always_comb begin
        s_a[0] = i_sample_x;
        s_a[1] = i_sample_y;
        s_a[2] = i_sample_z;
        s_b[0] = i_ref_x;
        s_b[1] = i_ref_y;
        s_b[2] = i_ref_z;
        for (int i = 0; i < 3; i++) begin
            s_ma[i] = s_a[i][W-1] ? (~s_a[i] + 1'b1) : s_a[i];
            s_mb[i] = s_b[i][W-1] ? (~s_b[i] + 1'b1) : s_b[i];
            n_s1_pab[i] = {{W{1'b0}}, s_ma[i]} * {{W{1'b0}}, s_mb[i]};
            n_s1_paa[i] = {{W{1'b0}}, s_ma[i]} * {{W{1'b0}}, s_ma[i]};
            n_s1_pbb[i] = {{W{1'b0}}, s_mb[i]} * {{W{1'b0}}, s_mb[i]};
            n_s1_neg[i] = s_a[i][W-1] ^ s_b[i][W-1];
        end
    end

    // stage 2: dot split by sign, squared lengths
    always_comb begin
        n_s2_pos = '0;
        n_s2_neg = '0;
        n_s2_la  = '0;
        n_s2_lb  = '0;
        for (int i = 0; i < 3; i++) begin
            if (r_s1_neg[i]) begin
                n_s2_neg = n_s2_neg + r_s1_pab[i];
            end else begin
                n_s2_pos = n_s2_pos + r_s1_pab[i];
            end
            n_s2_la = n_s2_la + r_s1_paa[i];
            n_s2_lb = n_s2_lb + r_s1_pbb[i];
        end
    end

    // stage 3: zero checks and sign cases
    always_comb begin
        s_dneg    = r_s2_pos < r_s2_neg;
        n_s3_dmag = s_dneg ? (r_s2_neg - r_s2_pos) : (r_s2_pos - r_s2_neg);
        n_s3_cmag = i_cos[COS_W-1] ? (~i_cos + 1'b1) : i_cos;
        n_s3_cls.dneg = s_dneg;
        if (r_s2_la == '0) begin
            n_s3_cls.status  = ST_A_ZERO;
            n_s3_cls.decided = 1'b1;
            n_s3_cls.tilt    = 1'b0;
        end else if (r_s2_lb == '0) begin
            n_s3_cls.status  = ST_B_ZERO;
            n_s3_cls.decided = 1'b1;
            n_s3_cls.tilt    = 1'b0;
        end else if (!s_dneg && (i_cos[COS_W-1] || i_cos == '0)) begin
            n_s3_cls.status  = ST_OK;
            n_s3_cls.decided = 1'b1;
            n_s3_cls.tilt    = 1'b0;
        end else if (s_dneg && !i_cos[COS_W-1]) begin
            n_s3_cls.status  = ST_OK;
            n_s3_cls.decided = 1'b1;
            n_s3_cls.tilt    = 1'b1;
        end else begin
            n_s3_cls.status  = ST_OK;
            n_s3_cls.decided = 1'b0;
            n_s3_cls.tilt    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else begin
            if (en1) r_s1_v <= i_valid;
            if (en2) r_s2_v <= r_s1_v;
            if (en3) r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_pab <= n_s1_pab;
            r_s1_paa <= n_s1_paa;
            r_s1_pbb <= n_s1_pbb;
            r_s1_neg <= n_s1_neg;
        end
        if (en2) begin
            r_s2_pos <= n_s2_pos;
            r_s2_neg <= n_s2_neg;
            r_s2_la  <= n_s2_la;
            r_s2_lb  <= n_s2_lb;
        end
        if (en3) begin
            r_s3_dmag <= n_s3_dmag;
            r_s3_la   <= r_s2_la;
            r_s3_lb   <= r_s2_lb;
            r_s3_cmag <= n_s3_cmag;
            r_s3_cls  <= n_s3_cls;
        end
    end

    assign o_valid = r_s3_v;
    assign o_dmag  = r_s3_dmag;
    assign o_len_a = r_s3_la;
    assign o_len_b = r_s3_lb;
    assign o_cmag  = r_s3_cmag;
    assign o_cls   = r_s3_cls;

endmodule

### rtl/core/vtad_cmp.sv
// Back pipeline: wide squares and products by partial products, final compare.
module vtad_cmp #(
    parameter int SAMPLE_WIDTH  = vtad_pkg::SAMPLE_WIDTH_DEF,
    parameter int COS_FRAC_BITS = vtad_pkg::COS_FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_hold,
    input  logic [2*SAMPLE_WIDTH-1:0]   i_dmag,
    input  logic [2*SAMPLE_WIDTH-1:0]   i_len_a,
    input  logic [2*SAMPLE_WIDTH-1:0]   i_len_b,
    input  logic [vtad_pkg::COS_W-1:0]  i_cmag,
    input  vtad_pkg::t_cls              i_cls,
    output logic                        o_valid,
    input  logic                        i_hold,
    output logic                        o_tilted,
    output logic [1:0]                  o_status
);
    import vtad_pkg::*;

    localparam int W   = SAMPLE_WIDTH;
    localparam int HW  = 2 * SAMPLE_WIDTH;
    localparam int QW  = 4 * SAMPLE_WIDTH;
    localparam int PW  = CM2_W + SAMPLE_WIDTH;
    localparam int SW  = PW + SAMPLE_WIDTH;
    localparam int SH  = 2 * COS_FRAC_BITS;
    localparam int CW  = QW + ((SH > CM2_W) ? SH : CM2_W);

    logic en1, en2, en3, en4, en5;

    logic [W-1:0] s_dh, s_dl, s_ah, s_al, s_bh, s_bl;

    logic             r_s1_v;
    logic [HW-1:0]    r_s1_dhh, r_s1_dhl, r_s1_dll;
    logic [HW-1:0]    r_s1_lhh, r_s1_lhl, r_s1_llh, r_s1_lll;
    logic [CM2_W-1:0] r_s1_cm2;
    t_cls             r_s1_cls;

    logic [QW-1:0]    n_s2_d2, n_s2_lab;
    logic             r_s2_v;
    logic [QW-1:0]    r_s2_d2, r_s2_lab;
    logic [CM2_W-1:0] r_s2_cm2;
    t_cls             r_s2_cls;

    logic [PW-1:0]    n_s3_rp [4];
    logic             r_s3_v;
    logic [PW-1:0]    r_s3_rp [4];
    logic [QW-1:0]    r_s3_d2;
    t_cls             r_s3_cls;

    logic [SW-1:0]    n_s4_slo, n_s4_shi;
    logic             r_s4_v;
    logic [SW-1:0]    r_s4_slo, r_s4_shi;
    logic [QW-1:0]    r_s4_d2;
    t_cls             r_s4_cls;

    logic [CW-1:0]    s_lhs, s_rhs;
    logic             n_s5_tilted;
    logic             r_s5_v;
    logic             r_s5_tilted;
    logic [1:0]       r_s5_status;

    assign en5    = !r_s5_v || !i_hold;
    assign en4    = !r_s4_v || en5;
    assign en3    = !r_s3_v || en4;
    assign en2    = !r_s2_v || en3;
    assign en1    = !r_s1_v || en2;
    assign o_hold = !en1;

    assign s_dh = i_dmag[HW-1:W];
    assign s_dl = i_dmag[W-1:0];
    assign s_ah = i_len_a[HW-1:W];
    assign s_al = i_len_a[W-1:0];
    assign s_bh = i_len_b[HW-1:W];
    assign s_bl = i_len_b[W-1:0];

    // stage 2: assemble d^2 and |a|^2*|b|^2
    assign n_s2_d2  = (QW'(r_s1_dhh) << HW) + (QW'(r_s1_dhl) << (W + 1)) + QW'(r_s1_dll);
    assign n_s2_lab = (QW'(r_s1_lhh) << HW)
                    + ((QW'(r_s1_lhl) + QW'(r_s1_llh)) << W) + QW'(r_s1_lll);

    // stage 3: c^2 times each W-bit chunk of the length product
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_s3_rp[k] = PW'(r_s2_cm2) * PW'(r_s2_lab[k*W +: W]);
        end
    end

    // stage 4: pairwise partial sums
    assign n_s4_slo = SW'(r_s3_rp[0]) + (SW'(r_s3_rp[1]) << W);
    assign n_s4_shi = SW'(r_s3_rp[2]) + (SW'(r_s3_rp[3]) << W);

    // stage 5: final sum and compare
    always_comb begin
        s_rhs = CW'(r_s4_slo) + (CW'(r_s4_shi) << HW);
        s_lhs = CW'(r_s4_d2) << SH;
        if (r_s4_cls.decided) begin
            n_s5_tilted = r_s4_cls.tilt;
        end else if (r_s4_cls.dneg) begin
            n_s5_tilted = s_lhs > s_rhs;
        end else begin
            n_s5_tilted = s_lhs < s_rhs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
        end else begin
            if (en1) r_s1_v <= i_valid;
            if (en2) r_s2_v <= r_s1_v;
            if (en3) r_s3_v <= r_s2_v;
            if (en4) r_s4_v <= r_s3_v;
            if (en5) r_s5_v <= r_s4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_dhh <= {{W{1'b0}}, s_dh} * {{W{1'b0}}, s_dh};
            r_s1_dhl <= {{W{1'b0}}, s_dh} * {{W{1'b0}}, s_dl};
            r_s1_dll <= {{W{1'b0}}, s_dl} * {{W{1'b0}}, s_dl};
            r_s1_lhh <= {{W{1'b0}}, s_ah} * {{W{1'b0}}, s_bh};
            r_s1_lhl <= {{W{1'b0}}, s_ah} * {{W{1'b0}}, s_bl};
            r_s1_llh <= {{W{1'b0}}, s_al} * {{W{1'b0}}, s_bh};
            r_s1_lll <= {{W{1'b0}}, s_al} * {{W{1'b0}}, s_bl};
            r_s1_cm2 <= CM2_W'({{COS_W{1'b0}}, i_cmag} * {{COS_W{1'b0}}, i_cmag});
            r_s1_cls <= i_cls;
        end
        if (en2) begin
            r_s2_d2  <= n_s2_d2;
            r_s2_lab <= n_s2_lab;
            r_s2_cm2 <= r_s1_cm2;
            r_s2_cls <= r_s1_cls;
        end
        if (en3) begin
            r_s3_rp  <= n_s3_rp;
            r_s3_d2  <= r_s2_d2;
            r_s3_cls <= r_s2_cls;
        end
        if (en4) begin
            r_s4_slo <= n_s4_slo;
            r_s4_shi <= n_s4_shi;
            r_s4_d2  <= r_s3_d2;
            r_s4_cls <= r_s3_cls;
        end
        if (en5) begin
            r_s5_tilted <= n_s5_tilted;
            r_s5_status <= r_s4_cls.status;
        end
    end

    assign o_valid  = r_s5_v;
    assign o_tilted = r_s5_tilted;
    assign o_status = r_s5_status;

endmodule

### rtl/core/vector_tilt_angle_detector_top.sv
// Top level of the vector tilt angle detector.
//
// Input channel: i_valid / o_stall with one signed three-axis sample word
// (i_sample_x/y/z). A word is taken on an edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall with o_tilted and o_status (0 ok,
// 1 sample vector zero, 2 reference vector zero; tilted is 0 unless ok).
// Config channel: i_cfg_valid / o_cfg_ready, i_cfg_index selects ref_x (0),
// ref_y (1), ref_z (2) or cos_threshold (3, signed Q2.COS_FRAC_BITS);
// other indexes are dropped. o_cfg_ready is always high. Write config only
// while the pipeline is empty.
// Pipeline: 8 register stages from input accept to o_valid (3 for products, sums
// and sign cases, 5 for the wide squares, the threshold product and the final
// compare).
// Throughput: one word per cycle while i_stall is low; every stage holds a valid bit.
// Stall: while i_stall is high the pipeline compacts into empty stages;
// o_stall rises only when every stage holds a word.
// Reset (synchronous, active low) empties the pipeline and loads a zero
// reference vector and a threshold of 14189 (about 30 degrees).
module vector_tilt_angle_detector_top #(
    parameter int SAMPLE_WIDTH  = vtad_pkg::SAMPLE_WIDTH_DEF,
    parameter int COS_FRAC_BITS = vtad_pkg::COS_FRAC_BITS_DEF,
    parameter int CFG_DATA_W    = (SAMPLE_WIDTH > vtad_pkg::COS_W) ? SAMPLE_WIDTH
                                                                  : vtad_pkg::COS_W
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]  i_sample_x,
    input  logic signed [SAMPLE_WIDTH-1:0]  i_sample_y,
    input  logic signed [SAMPLE_WIDTH-1:0]  i_sample_z,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_tilted,
    output logic [1:0]                      o_status,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [vtad_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0]           i_cfg_data
);
    import vtad_pkg::*;

    logic signed [SAMPLE_WIDTH-1:0] w_ref_x, w_ref_y, w_ref_z;
    logic signed [COS_W-1:0]        w_cos;
    logic                           w_mid_valid, w_mid_hold;
    logic [2*SAMPLE_WIDTH-1:0]      w_dmag, w_len_a, w_len_b;
    logic [COS_W-1:0]               w_cmag;
    t_cls                           w_cls;

    vtad_cfg #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .CFG_DATA_W   (CFG_DATA_W)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_ref_x     (w_ref_x),
        .o_ref_y     (w_ref_y),
        .o_ref_z     (w_ref_z),
        .o_cos       (w_cos)
    );

    vtad_dot #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dot (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_hold     (o_stall),
        .i_sample_x (i_sample_x),
        .i_sample_y (i_sample_y),
        .i_sample_z (i_sample_z),
        .i_ref_x    (w_ref_x),
        .i_ref_y    (w_ref_y),
        .i_ref_z    (w_ref_z),
        .i_cos      (w_cos),
        .o_valid    (w_mid_valid),
        .i_hold     (w_mid_hold),
        .o_dmag     (w_dmag),
        .o_len_a    (w_len_a),
        .o_len_b    (w_len_b),
        .o_cmag     (w_cmag),
        .o_cls      (w_cls)
    );

    vtad_cmp #(
        .SAMPLE_WIDTH  (SAMPLE_WIDTH),
        .COS_FRAC_BITS (COS_FRAC_BITS)
    ) u_cmp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_mid_valid),
        .o_hold   (w_mid_hold),
        .i_dmag   (w_dmag),
        .i_len_a  (w_len_a),
        .i_len_b  (w_len_b),
        .i_cmag   (w_cmag),
        .i_cls    (w_cls),
        .o_valid  (o_valid),
        .i_hold   (i_stall),
        .o_tilted (o_tilted),
        .o_status (o_status)
    );

endmodule

### rtl/core/vtad_chk.sv
// Port-level checker for the tilt detector, bound to the top level.
`include "vector_tilt_angle_detector_top_macros.svh"

module vtad_chk #(
    parameter int SAMPLE_WIDTH = vtad_pkg::SAMPLE_WIDTH_DEF
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            o_stall,
    input logic signed [SAMPLE_WIDTH-1:0]  i_sample_x,
    input logic signed [SAMPLE_WIDTH-1:0]  i_sample_y,
    input logic signed [SAMPLE_WIDTH-1:0]  i_sample_z,
    input logic                            o_valid,
    input logic                            i_stall,
    input logic                            o_tilted,
    input logic [1:0]                      o_status
);
    import vtad_pkg::*;

    `VTAD_ASSERT_NOW(a_status_code, o_valid, (o_status == ST_OK) || (o_status == ST_A_ZERO) || (o_status == ST_B_ZERO), "status word carries an unused code")
    `VTAD_ASSERT_NOW(a_err_no_tilt, o_valid && (o_status != ST_OK), !o_tilted, "tilt flagged on a zero-length vector")
    `VTAD_ASSERT_NOW(a_stall_full, o_stall, o_valid && i_stall, "input stalled while output side is free")
    `VTAD_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_tilted) && $stable(o_status), "stalled result word changed")
    `VTAD_ASSERT_NEXT(a_in_hold, i_valid && o_stall, i_valid && $stable(i_sample_x) && $stable(i_sample_y) && $stable(i_sample_z), "stalled sample word changed")

endmodule

bind vector_tilt_angle_detector_top vtad_chk #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_vtad_chk (.*);

### tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for vector_tilt_angle_detector_top: directed table, then random phases.
module tb;
    import vtad_pkg::*;

    localparam int SW           = SAMPLE_WIDTH_DEF;
    localparam int CFB          = COS_FRAC_BITS_DEF;
    localparam int CFG_W        = (SW > COS_W) ? SW : COS_W;
    localparam int S_MIN        = -(1 << (SW - 1));
    localparam int S_MAX        = (1 << (SW - 1)) - 1;
    localparam int DRAIN_CYCLES = 16;
    localparam int N_PHASES     = 12;
    localparam int PHASE_ITEMS  = 96;
    localparam int HOLD_CYCLES  = 80;
    localparam int MAX_REPORTS  = 10;
    localparam int N_DIR        = 33;
    localparam longint TIMEOUT_NS = 64'd10_000_000;

    typedef struct packed {
        logic       tilt;
        logic [1:0] status;
    } t_tilt_result;

    typedef struct {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
        int                   x;
        int                   y;
        int                   z;
        logic                 known;
        t_tilt_result         res;
    } t_dir_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic signed [SW-1:0]  i_sample_x;
    logic signed [SW-1:0]  i_sample_y;
    logic signed [SW-1:0]  i_sample_z;
    logic                  o_valid;
    logic                  i_stall;
    logic                  o_tilted;
    logic [1:0]            o_status;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_W-1:0]      i_cfg_data;

    logic signed [SW-1:0]    cfg_ref_x;
    logic signed [SW-1:0]    cfg_ref_y;
    logic signed [SW-1:0]    cfg_ref_z;
    logic signed [COS_W-1:0] cfg_cos;

    t_tilt_result pending_tilt_q[$];
    t_tilt_result got_tilt;
    int           tilt_mismatch_cnt;
    logic         tx_quiet;
    logic         rx_quiet;
    logic         hold_req;
    int           stall_left;
    t_dir_row     dir_rows[N_DIR];

    vector_tilt_angle_detector_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_sample_x  (i_sample_x),
        .i_sample_y  (i_sample_y),
        .i_sample_z  (i_sample_z),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_tilted    (o_tilted),
        .o_status    (o_status),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    function automatic t_tilt_result predict_tilt(input logic signed [SW-1:0] ax,
                                                  input logic signed [SW-1:0] ay,
                                                  input logic signed [SW-1:0] az);
        t_tilt_result res;
        longint       dot;
        longint       len_a;
        longint       len_b;
        longint       dmag;
        longint       cm;
        logic [127:0] dw;
        logic [127:0] lhs;
        logic [127:0] rhs;
        logic         dneg;
        res.tilt   = 1'b0;
        res.status = ST_OK;
        dot   = longint'(ax) * longint'(cfg_ref_x) + longint'(ay) * longint'(cfg_ref_y)
              + longint'(az) * longint'(cfg_ref_z);
        len_a = longint'(ax) * longint'(ax) + longint'(ay) * longint'(ay)
              + longint'(az) * longint'(az);
        len_b = longint'(cfg_ref_x) * longint'(cfg_ref_x)
              + longint'(cfg_ref_y) * longint'(cfg_ref_y)
              + longint'(cfg_ref_z) * longint'(cfg_ref_z);
        if (len_a == 0) begin
            res.status = ST_A_ZERO;
        end else if (len_b == 0) begin
            res.status = ST_B_ZERO;
        end else begin
            dneg = dot < 0;
            dmag = dneg ? -dot : dot;
            if (!dneg && cfg_cos <= 0) begin
                res.tilt = 1'b0;
            end else if (dneg && cfg_cos >= 0) begin
                res.tilt = 1'b1;
            end else begin
                cm = longint'(cfg_cos);
                if (cm < 0) begin
                    cm = -cm;
                end
                dw  = 128'(dmag);
                lhs = (dw * dw) << (2 * CFB);
                rhs = 128'(cm * cm);
                rhs = rhs * 128'(len_a);
                rhs = rhs * 128'(len_b);
                res.tilt = dneg ? (lhs > rhs) : (lhs < rhs);
            end
        end
        return res;
    endfunction

    function automatic t_dir_row row_cfg(input logic [CFG_IDX_W-1:0] idx, input int data);
        t_dir_row r;
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.data   = CFG_W'(data);
        r.x      = 0;
        r.y      = 0;
        r.z      = 0;
        r.known  = 1'b0;
        r.res    = '0;
        return r;
    endfunction

    function automatic t_dir_row row_exp(input int x, input int y, input int z,
                                         input logic known, input logic tilt,
                                         input logic [1:0] status);
        t_dir_row r;
        r.is_cfg     = 1'b0;
        r.idx        = REG_REF_X;
        r.data       = '0;
        r.x          = x;
        r.y          = y;
        r.z          = z;
        r.known      = known;
        r.res.tilt   = tilt;
        r.res.status = status;
        return r;
    endfunction

    function automatic int near_axis(input int base, input int nb);
        int v;
        v = base + $urandom_range(0, 1 << nb) - (1 << nb) / 2;
        if (v > S_MAX) begin
            v = S_MAX;
        end else if (v < S_MIN) begin
            v = S_MIN;
        end
        return v;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_index = idx;
        i_cfg_data  = data;
        i_cfg_valid = 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        case (idx)
            REG_REF_X: cfg_ref_x = data[SW-1:0];
            REG_REF_Y: cfg_ref_y = data[SW-1:0];
            REG_REF_Z: cfg_ref_z = data[SW-1:0];
            REG_COS:   cfg_cos   = data[COS_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic wait_drain();
        i_valid = 1'b0;
        while (pending_tilt_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic send_sample(input logic signed [SW-1:0] sx, input logic signed [SW-1:0] sy,
                               input logic signed [SW-1:0] sz, input logic known,
                               input t_tilt_result res);
        int   gap;
        int   r;
        logic taken;
        gap = 0;
        if (!tx_quiet) begin
            r = $urandom_range(0, 99);
            if (r >= 97) begin
                gap = $urandom_range(20, 40);
            end else if (r >= 88) begin
                gap = $urandom_range(4, 10);
            end else if (r >= 55) begin
                gap = $urandom_range(1, 3);
            end
        end
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_sample_x = sx;
        i_sample_y = sy;
        i_sample_z = sz;
        i_valid    = 1'b1;
        taken      = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = !o_stall;
            if (taken) begin
                pending_tilt_q.push_back(known ? res : predict_tilt(sx, sy, sz));
            end
            @(negedge i_clk);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("FAIL vector_tilt_angle_detector_top");
        $finish;
    end

    // receiver: random stall bursts, plus one long hold on request
    initial begin
        i_stall    = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left = stall_left - 1;
                i_stall    = 1'b1;
            end else if (hold_req) begin
                stall_left = HOLD_CYCLES - 1;
                hold_req   = 1'b0;
                i_stall    = 1'b1;
            end else if (!rx_quiet && $urandom_range(0, 99) < 25) begin
                case ($urandom_range(0, 99)) inside
                    [0:84]:  stall_left = $urandom_range(0, 2);
                    [85:96]: stall_left = $urandom_range(3, 9);
                    default: stall_left = $urandom_range(19, 39);
                endcase
                i_stall = 1'b1;
            end else begin
                i_stall = 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_tilt_q.size() == 0) begin
                if (tilt_mismatch_cnt < MAX_REPORTS) begin
                    $display("%0t: result word with none expected: tilted=%0b status=%0d",
                             $realtime, o_tilted, o_status);
                end
                tilt_mismatch_cnt = tilt_mismatch_cnt + 1;
            end else begin
                got_tilt = pending_tilt_q.pop_front();
                if (o_tilted !== got_tilt.tilt || o_status !== got_tilt.status) begin
                    if (tilt_mismatch_cnt < MAX_REPORTS) begin
                        $display("%0t: expected tilted=%0b status=%0d, got tilted=%0b status=%0d",
                                 $realtime, got_tilt.tilt, got_tilt.status, o_tilted,
                                 o_status);
                    end
                    tilt_mismatch_cnt = tilt_mismatch_cnt + 1;
                end
            end
        end
    end

    initial begin
        int                   rv[3];
        int                   cv;
        int                   r;
        int                   k;
        int                   sgn;
        int                   nb;
        int                   ext[5];
        logic signed [SW-1:0] vx;
        logic signed [SW-1:0] vy;
        logic signed [SW-1:0] vz;

        ext = '{S_MIN, S_MAX, 0, -1, 1};
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_sample_x  = '0;
        i_sample_y  = '0;
        i_sample_z  = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_REF_X;
        i_cfg_data  = '0;
        tx_quiet    = 1'b0;
        rx_quiet    = 1'b0;
        hold_req    = 1'b0;
        tilt_mismatch_cnt = 0;
        cfg_ref_x   = '0;
        cfg_ref_y   = '0;
        cfg_ref_z   = '0;
        cfg_cos     = COS_RESET;

        dir_rows = '{
            // reset state: zero reference
            row_exp(0, 0, 0, 1, 0, ST_A_ZERO),
            row_exp(1, 0, 0, 1, 0, ST_B_ZERO),
            row_exp(S_MIN, S_MIN, S_MIN, 1, 0, ST_B_ZERO),
            row_cfg(REG_REF_X, 16384),
            row_cfg(REG_REF_Y, 0),
            row_cfg(REG_REF_Z, 0),
            row_exp(16384, 0, 0, 1, 0, ST_OK),
            row_exp(0, 16384, 0, 1, 1, ST_OK),
            row_exp(-16384, 0, 0, 1, 1, ST_OK),
            row_exp(0, 0, 0, 1, 0, ST_A_ZERO),
            row_exp(S_MAX, S_MAX, S_MAX, 0, 0, ST_OK),
            row_exp(S_MIN, S_MIN, S_MIN, 1, 1, ST_OK),
            row_exp(16384, 9459, 0, 0, 0, ST_OK),
            // cosine exactly 1.0: parallel is on the boundary
            row_cfg(REG_COS, 16384),
            row_exp(16384, 0, 0, 1, 0, ST_OK),
            row_exp(S_MAX, 1, 0, 0, 0, ST_OK),
            row_cfg(REG_COS, -16384),
            row_exp(-16384, 0, 0, 1, 0, ST_OK),
            row_exp(16384, 0, 0, 1, 0, ST_OK),
            row_cfg(REG_COS, S_MAX),
            row_exp(16384, 0, 0, 1, 1, ST_OK),
            row_exp(-16384, 0, 0, 1, 1, ST_OK),
            row_cfg(REG_COS, S_MIN),
            row_exp(-16384, 0, 0, 1, 0, ST_OK),
            row_exp(0, 16384, 0, 1, 0, ST_OK),
            row_cfg(REG_COS, 0),
            row_exp(0, 16384, 0, 1, 0, ST_OK),
            row_exp(-1, 0, 0, 1, 1, ST_OK),
            // unused indexes are dropped
            row_cfg(REG_COS + 3'd2, 'h1234),
            row_exp(1, 0, 0, 1, 0, ST_OK),
            row_cfg(REG_REF_Y, S_MAX),
            row_exp(S_MIN, S_MAX, -1, 0, 0, ST_OK),
            row_exp(S_MAX, S_MIN, 1, 0, 0, ST_OK)
        };

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[n]) begin
            if (dir_rows[n].is_cfg) begin
                wait_drain();
                write_reg(dir_rows[n].idx, dir_rows[n].data);
            end else begin
                send_sample(SW'(dir_rows[n].x), SW'(dir_rows[n].y), SW'(dir_rows[n].z),
                            dir_rows[n].known, dir_rows[n].res);
            end
        end

        for (int p = 0; p < N_PHASES; p++) begin
            wait_drain();
            if (p % 2 == 1) begin
                write_reg(REG_COS + CFG_IDX_W'($urandom_range(1, 4)), CFG_W'($urandom));
            end
            r = (p == 0) ? 0 : (p == 1) ? 1 : $urandom_range(2, 5);
            case (r)
                0: rv = '{S_MAX, S_MAX, S_MAX};
                1: rv = '{S_MIN, S_MIN, S_MIN};
                3: begin
                    foreach (rv[a]) begin
                        rv[a] = $urandom_range(0, 8) - 4;
                    end
                end
                4: begin
                    rv = '{0, 0, 0};
                    rv[$urandom_range(0, 2)] = int'($signed(SW'($urandom)));
                end
                default: begin
                    foreach (rv[a]) begin
                        rv[a] = int'($signed(SW'($urandom)));
                    end
                end
            endcase
            write_reg(REG_REF_X, CFG_W'(rv[0]));
            write_reg(REG_REF_Y, CFG_W'(rv[1]));
            write_reg(REG_REF_Z, CFG_W'(rv[2]));
            case (p)
                0: cv = 16384;
                1: cv = -16384;
                2: cv = S_MAX;
                3: cv = S_MIN;
                4: cv = 0;
                default: cv = ($urandom_range(0, 3) == 0) ? int'($signed(16'($urandom)))
                                                          : $urandom_range(0, 32768) - 16384;
            endcase
            write_reg(REG_COS, CFG_W'(cv));

            tx_quiet = (p % 4 == 1) || (p == 2);
            rx_quiet = (p % 3 == 0);
            // long receiver hold while samples keep coming back to back
            if (p == 2) begin
                hold_req = 1'b1;
            end

            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 5 && i == PHASE_ITEMS / 2) begin
                    wait_drain();
                end
                r = $urandom_range(0, 99);
                if (r < 30) begin
                    vx = SW'($urandom);
                    vy = SW'($urandom);
                    vz = SW'($urandom);
                end else if (r < 60) begin
                    // close to the reference direction, either sign
                    k   = $urandom_range(0, 2);
                    sgn = ($urandom_range(0, 2) == 0) ? -1 : 1;
                    nb  = $urandom_range(0, 14);
                    vx  = SW'(near_axis(sgn * (int'(cfg_ref_x) >>> k), nb));
                    vy  = SW'(near_axis(sgn * (int'(cfg_ref_y) >>> k), nb));
                    vz  = SW'(near_axis(sgn * (int'(cfg_ref_z) >>> k), nb));
                end else if (r < 75) begin
                    vx = SW'($urandom_range(0, 4) - 2);
                    vy = SW'($urandom_range(0, 4) - 2);
                    vz = SW'($urandom_range(0, 4) - 2);
                end else begin
                    vx = SW'(ext[$urandom_range(0, 4)]);
                    vy = SW'(ext[$urandom_range(0, 4)]);
                    vz = SW'(ext[$urandom_range(0, 4)]);
                end
                send_sample(vx, vy, vz, 1'b0, '0);
            end
        end

        wait_drain();
        if (tilt_mismatch_cnt == 0) begin
            $display("PASS vector_tilt_angle_detector_top");
        end else begin
            $display("FAIL vector_tilt_angle_detector_top");
        end
        $finish;
    end
endmodule
